// ----- hdl/ght_pkg.sv -----
// Shared widths, operation codes and status codes for the handle table.
`timescale 1ns / 1ps
package ght_pkg;

  localparam int MODE_W     = 2;
  localparam int OBJ_W      = 32;
  localparam int GEN_W      = 32;
  localparam int IDX_PORT_W = 8;
  localparam int STATUS_W   = 2;

  typedef logic [MODE_W-1:0]   mode_t;
  typedef logic [STATUS_W-1:0] status_t;
  typedef logic [OBJ_W-1:0]    obj_t;
  typedef logic [GEN_W-1:0]    gen_t;
  typedef logic [IDX_PORT_W-1:0] port_idx_t;

  localparam mode_t MODE_REGISTER   = 2'd0;
  localparam mode_t MODE_UNREGISTER = 2'd1;
  localparam mode_t MODE_LOOKUP     = 2'd2;

  localparam status_t ST_OK         = 2'd0;
  localparam status_t ST_FULL       = 2'd1;
  localparam status_t ST_NOT_FOUND  = 2'd2;
  localparam status_t ST_BAD_HANDLE = 2'd3;

  localparam gen_t GEN_FIRST = 32'd1;

endpackage

// ----- hdl/ght_in_if.sv -----
// Request channel of the handle table: valid/ready plus the request fields.
`timescale 1ns / 1ps
interface ght_in_if
  import ght_pkg::*;
();
  logic      valid;
  logic      ready;
  mode_t     mode;
  obj_t      object_id;
  port_idx_t entry_index;
  gen_t      entry_generation;

  modport source (output valid, output mode, output object_id, output entry_index,
                  output entry_generation, input ready);
  modport sink   (input valid, input mode, input object_id, input entry_index,
                  input entry_generation, output ready);
endinterface

// ----- hdl/ght_out_if.sv -----
// Result channel of the handle table: valid/ready plus the result fields.
`timescale 1ns / 1ps
interface ght_out_if
  import ght_pkg::*;
();
  logic      valid;
  logic      ready;
  status_t   status;
  port_idx_t handle_index;
  gen_t      handle_generation;
  obj_t      found_object;

  modport source (output valid, output status, output handle_index,
                  output handle_generation, output found_object, input ready);
  modport sink   (input valid, input status, input handle_index,
                  input handle_generation, input found_object, output ready);
endinterface

// ----- hdl/ght_store.sv -----
// One-write one-read RAM with registered read and write-to-read bypass.
`timescale 1ns / 1ps
module ght_store #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 8
) (
  input  logic                     clk,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // a write to the address being read lands in the read register directly
  always_ff @(posedge clk) begin
    if (rd_en) begin
      if (wr_en && (wr_addr == rd_addr)) begin
        rd_data_r <= wr_data;
      end else begin
        rd_data_r <= mem[rd_addr];
      end
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ----- hdl/generational_handle_table_core.sv -----
// Generational handle table: slot store, free-slot FIFO and request pipeline.
//
// Usage:
//   in_req carries one request per valid/ready transfer: register (store an
//   object id, get back index and generation), unregister (free a slot whose
//   object id matches) or lookup (return the object id of a live handle).
//   out_rsp carries exactly one result per request, in request order.
//   Each request is registered in the work stage and its result then in the
//   result register that drives out_rsp. Throughput: one request per cycle
//   while out_rsp does not stall, set by the single read and single write
//   port of the slot store and of the free-slot FIFO; hazards between
//   back-to-back requests on the same slot are bypassed at the RAM.
//   Freed slots are reused oldest first; a fresh slot starts at generation 1
//   and a reused one gets its old generation plus one, wrapping at 32 bits.
//   Reset empties the FIFO and the table (no clearing pass; RAM contents are
//   never used before they are written). When out_rsp stalls, the result is
//   held, one more request is taken into the work stage, and then in_req
//   drops ready until the result is taken.
`timescale 1ns / 1ps
module generational_handle_table_core
  import ght_pkg::*;
#(
  parameter int SLOTS = 256
) (
  input  logic         clk,
  input  logic         rst_n,
  ght_in_if.sink       in_req,
  ght_out_if.source    out_rsp
);

  localparam int IDX_W  = $clog2(SLOTS);
  localparam int CNT_W  = $clog2(SLOTS + 1);
  localparam int CMP_W  = (CNT_W > IDX_PORT_W) ? CNT_W : IDX_PORT_W;
  localparam int SLOT_W = 1 + GEN_W + OBJ_W;
  localparam int Q_W    = IDX_W + GEN_W;

  // work stage
  logic      s1_vld_r;
  mode_t     s1_mode_r;
  obj_t      s1_obj_r;
  port_idx_t s1_idx_r;
  gen_t      s1_gen_r;

  // queue and table bookkeeping
  logic [IDX_W-1:0] head_r, head_nxt;
  logic [IDX_W-1:0] tail_r, tail_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] hw_r, hw_nxt;

  // result register
  logic      out_vld_r;
  status_t   out_status_r, st_nxt;
  port_idx_t out_idx_r, hidx_nxt;
  gen_t      out_gen_r, hgen_nxt;
  obj_t      out_obj_r, found_nxt;

  logic in_fire, adv;

  logic [SLOT_W-1:0] slot_rd, slot_wdata;
  logic [IDX_W-1:0]  slot_waddr;
  logic              slot_we;
  logic [Q_W-1:0]    q_rd, q_wdata;
  logic              q_we;

  logic             rd_act;
  gen_t             rd_gen;
  obj_t             rd_obj;
  logic [IDX_W-1:0] q_idx;
  gen_t             q_gen;
  logic [IDX_W-1:0] s1_addr;
  logic             in_range;
  logic [IDX_W-1:0] new_slot;
  gen_t             new_gen;

  assign adv      = s1_vld_r && (!out_vld_r || out_rsp.ready);
  assign in_req.ready = !s1_vld_r || adv;
  assign in_fire  = in_req.valid && in_req.ready;

  ght_store #(.DEPTH(SLOTS), .WIDTH(SLOT_W)) u_slots (
    .clk     (clk),
    .rd_en   (in_fire),
    .rd_addr (IDX_W'(in_req.entry_index)),
    .rd_data (slot_rd),
    .wr_en   (slot_we),
    .wr_addr (slot_waddr),
    .wr_data (slot_wdata)
  );

  // keep the FIFO head entry prefetched
  ght_store #(.DEPTH(SLOTS), .WIDTH(Q_W)) u_free_q (
    .clk     (clk),
    .rd_en   (1'b1),
    .rd_addr (head_nxt),
    .rd_data (q_rd),
    .wr_en   (q_we),
    .wr_addr (tail_r),
    .wr_data (q_wdata)
  );

  assign {rd_act, rd_gen, rd_obj} = slot_rd;
  assign {q_idx, q_gen}           = q_rd;
  assign s1_addr  = IDX_W'(s1_idx_r);
  assign in_range = CMP_W'(s1_idx_r) < CMP_W'(hw_r);

  always_comb begin
    st_nxt     = ST_NOT_FOUND;
    hidx_nxt   = '0;
    hgen_nxt   = '0;
    found_nxt  = '0;
    head_nxt   = head_r;
    tail_nxt   = tail_r;
    count_nxt  = count_r;
    hw_nxt     = hw_r;
    slot_we    = 1'b0;
    slot_waddr = s1_addr;
    slot_wdata = '0;
    q_we       = 1'b0;
    q_wdata    = {s1_addr, rd_gen};
    new_slot   = q_idx;
    new_gen    = q_gen + 32'd1;
    if (s1_vld_r) begin
      unique case (s1_mode_r)
        MODE_REGISTER: begin
          priority if (count_r != '0) begin
            // reuse the oldest freed slot
            new_slot = q_idx;
            new_gen  = q_gen + 32'd1;
            st_nxt   = ST_OK;
            if (adv) begin
              head_nxt  = (head_r == IDX_W'(SLOTS - 1)) ? '0 : head_r + 1'b1;
              count_nxt = count_r - 1'b1;
            end
          end else if (hw_r != CNT_W'(SLOTS)) begin
            new_slot = IDX_W'(hw_r);
            new_gen  = GEN_FIRST;
            st_nxt   = ST_OK;
            if (adv) begin
              hw_nxt = hw_r + 1'b1;
            end
          end else begin
            st_nxt = ST_FULL;
          end
          if (st_nxt == ST_OK) begin
            hidx_nxt   = IDX_PORT_W'(new_slot);
            hgen_nxt   = new_gen;
            slot_we    = adv;
            slot_waddr = new_slot;
            slot_wdata = {1'b1, new_gen, s1_obj_r};
          end
        end
        MODE_UNREGISTER: begin
          if (in_range && rd_act && (rd_obj == s1_obj_r)) begin
            st_nxt     = ST_OK;
            slot_we    = adv;
            slot_wdata = {1'b0, rd_gen, {OBJ_W{1'b0}}};
            q_we       = adv;
            if (adv) begin
              tail_nxt  = (tail_r == IDX_W'(SLOTS - 1)) ? '0 : tail_r + 1'b1;
              count_nxt = count_r + 1'b1;
            end
          end else begin
            st_nxt = ST_BAD_HANDLE;
          end
        end
        MODE_LOOKUP: begin
          if (in_range && rd_act && (rd_gen == s1_gen_r)) begin
            st_nxt    = ST_OK;
            found_nxt = rd_obj;
          end
        end
        default: begin
          st_nxt = ST_NOT_FOUND;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      head_r    <= '0;
      tail_r    <= '0;
      count_r   <= '0;
      hw_r      <= '0;
    end else begin
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
      hw_r    <= hw_nxt;
      if (in_fire) begin
        s1_vld_r <= 1'b1;
      end else if (adv) begin
        s1_vld_r <= 1'b0;
      end
      if (adv) begin
        out_vld_r <= 1'b1;
      end else if (out_rsp.ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_mode_r <= in_req.mode;
      s1_obj_r  <= in_req.object_id;
      s1_idx_r  <= in_req.entry_index;
      s1_gen_r  <= in_req.entry_generation;
    end
    if (adv) begin
      out_status_r <= st_nxt;
      out_idx_r    <= hidx_nxt;
      out_gen_r    <= hgen_nxt;
      out_obj_r    <= found_nxt;
    end
  end

  assign out_rsp.valid             = out_vld_r;
  assign out_rsp.status            = out_status_r;
  assign out_rsp.handle_index      = out_idx_r;
  assign out_rsp.handle_generation = out_gen_r;
  assign out_rsp.found_object      = out_obj_r;

  a_free_le_hw: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= hw_r)
    else $error("free count exceeds opened slots");

  a_hw_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    1'b1 |=> hw_r >= $past(hw_r))
    else $error("high-water mark moved backward");

  a_empty_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0) |-> (head_r == tail_r))
    else $error("empty free queue with unequal pointers");

  a_full_only_when_exhausted: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && (s1_mode_r == MODE_REGISTER) && (st_nxt == ST_FULL))
      |-> ((count_r == '0) && (hw_r == CNT_W'(SLOTS))))
    else $error("full reported with slots available");

endmodule
